// ===== src/bpfa_pkg.sv =====
// bpfa_pkg: shared types and constants of the bitmap page frame allocator
// request and status codes, sequencer states, fixed field widths
// no dependencies
package bpfa_pkg;

    localparam int CNT_W      = 16;
    localparam int ADDR_W     = 27;
    localparam int CFG_W      = 16;
    localparam int PAGE_SHIFT = 12;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - ADDR_W - CNT_W;

    localparam logic [CFG_W-1:0] PAGE_TOTAL_RST = 16'd32768;
    localparam logic [CFG_W-1:0] RESERVED_RST   = 16'd256;

    localparam logic [0:0] REG_PAGE_TOTAL = 1'b0;
    localparam logic [0:0] REG_RESERVED   = 1'b1;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NO_MEMORY     = 2'd1,
        ST_NOT_ALLOCATED = 2'd2,
        ST_OUT_OF_RANGE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV,
        S_FREE_RD,
        S_FREE_CHK,
        S_RESP
    } state_t;

endpackage

// ===== src/bitmap_page_frame_allocator_top.sv =====
// bitmap_page_frame_allocator_top: first-fit page frame allocator over a used-bit bitmap
// one bitmap memory, one shared adder and a small sequencer
// depends on bpfa_pkg
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tdata page_address, tuser req_type
// m_       out  m_tvalid/m_tready   tdata result_address, used_count; tuser status
// cfg_     in   cfg_we              cfg_index, cfg_wdata
//
// alloc: S_SCAN_RD and S_SCAN_CHK per word scanned; no memory once the scan runs off the total
// free: word index by a constant reciprocal multiply in S_DIV, then S_FREE_RD, S_FREE_CHK, S_RESP
// init: a sweep over all bitmap words, one bitmap word written per cycle
// after reset a clearing pass over all bitmap words runs before the first request is taken
// one request at a time; a finished result waits in the output register while the next
// request is taken in, and a full output register holds the sequencer in its response state
module bitmap_page_frame_allocator_top #(
    parameter int MAX_PAGES = 32768,
    parameter int WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bpfa_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] page_address
    input  logic [1:0]                     s_tuser,   // [1:0] req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bpfa_pkg::M_TDATA_W-1:0] m_tdata,   // [26:0] result_address, [42:27] used_count
    output logic [1:0]                     m_tuser,   // [1:0] status
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_index,
    input  logic [bpfa_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIW        = $clog2(WORD_BITS);
    localparam int PW         = $clog2(MAX_PAGES + 1);
    localparam int XW         = PW + 1;
    localparam int PGB        = $clog2(MAX_PAGES);
    localparam int DK         = PGB + BIW;
    localparam int MW         = PGB + 2;
    localparam int PRW        = PGB + MW;
    localparam logic [MW-1:0] DIV_M =
        MW'(((64'd1 << DK) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
    localparam logic [WORD_BITS-1:0] FULL = {WORD_BITS{1'b1}};

    bpfa_pkg::state_t  state_reg, state_next;
    bpfa_pkg::status_t res_status_reg, res_status_next;
    bpfa_pkg::status_t out_status_reg, out_status_next;

    logic [bpfa_pkg::CFG_W-1:0]  page_total_reg, reserved_reg;
    logic [WIW:0]                idx_reg, idx_next;
    logic [XW-1:0]               base_reg, base_next;
    logic [PW-1:0]               resv_reg, resv_next;
    logic                        sweep_init_reg, sweep_init_next;
    logic [bpfa_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BIW-1:0]              rem_reg, rem_next;
    logic [WIW-1:0]              q_reg, q_next;
    logic [PGB-1:0]              dvd_reg, dvd_next;
    logic [bpfa_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic                        m_valid_reg, m_valid_next;
    logic [bpfa_pkg::ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [bpfa_pkg::CNT_W-1:0]  out_count_reg, out_count_next;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [WIW-1:0]       mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [XW-1:0]        alu_a, alu_b, alu_sum;
    logic                 alu_cin;

    logic [PW-1:0]        eff_total, resv_eff;
    logic [BIW-1:0]       first_zero;
    logic [PRW-1:0]       div_prod;
    logic [XW-1:0]        resv_diff;
    logic [WORD_BITS-1:0] init_mask;

    // effective totals
    assign eff_total = (32'(page_total_reg) > 32'(MAX_PAGES)) ? PW'(MAX_PAGES)
                                                               : PW'(page_total_reg);
    assign resv_eff  = (32'(reserved_reg) > 32'(eff_total)) ? eff_total : PW'(reserved_reg);

    // shared adder
    assign alu_sum = alu_a + alu_b + XW'(alu_cin);

    // word index by constant reciprocal multiply
    assign div_prod = PRW'(dvd_reg) * PRW'(DIV_M);

    // reserved-page mask of the word being swept
    assign resv_diff = XW'(resv_reg) - base_reg;
    always_comb begin
        if (XW'(resv_reg) <= base_reg) begin
            init_mask = '0;
        end else if (resv_diff >= XW'(WORD_BITS)) begin
            init_mask = FULL;
        end else begin
            init_mask = ~(FULL << resv_diff);
        end
    end

    // lowest clear bit of the word read
    always_comb begin
        first_zero = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!rd_data_reg[b]) begin
                first_zero = BIW'(b);
            end
        end
    end

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_total_reg <= bpfa_pkg::PAGE_TOTAL_RST;
            reserved_reg   <= bpfa_pkg::RESERVED_RST;
        end else if (cfg_we) begin
            if (cfg_index == bpfa_pkg::REG_PAGE_TOTAL) begin
                page_total_reg <= cfg_wdata;
            end else begin
                reserved_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bpfa_pkg::S_SWEEP;
            idx_reg        <= '0;
            base_reg       <= '0;
            resv_reg       <= '0;
            sweep_init_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            base_reg       <= base_next;
            resv_reg       <= resv_next;
            sweep_init_reg <= sweep_init_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        dvd_reg        <= dvd_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_count_reg  <= out_count_next;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        resv_next       = resv_reg;
        sweep_init_next = sweep_init_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        dvd_next        = dvd_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_count_next  = out_count_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg[WIW-1:0];
        mem_raddr = idx_reg[WIW-1:0];
        mem_wdata = '0;
        alu_a     = base_reg;
        alu_b     = XW'(WORD_BITS);
        alu_cin   = 1'b0;

        unique case (state_reg)
            bpfa_pkg::S_SWEEP: begin
                mem_we    = 1'b1;
                mem_wdata = init_mask;
                base_next = alu_sum;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == (WIW+1)'(WORD_COUNT - 1)) begin
                    cnt_next   = bpfa_pkg::CNT_W'(resv_reg);
                    state_next = sweep_init_reg ? bpfa_pkg::S_RESP : bpfa_pkg::S_IDLE;
                end
            end

            bpfa_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    res_status_next = bpfa_pkg::ST_OK;
                    res_addr_next   = '0;
                    idx_next        = '0;
                    base_next       = '0;
                    unique case (s_tuser)
                        bpfa_pkg::REQ_ALLOC: begin
                            if (32'(cnt_reg) >= 32'(eff_total)) begin
                                res_status_next = bpfa_pkg::ST_NO_MEMORY;
                                state_next      = bpfa_pkg::S_RESP;
                            end else begin
                                state_next = bpfa_pkg::S_SCAN_RD;
                            end
                        end
                        bpfa_pkg::REQ_FREE: begin
                            if (32'(s_tdata[31:bpfa_pkg::PAGE_SHIFT]) >= 32'(eff_total)) begin
                                res_status_next = bpfa_pkg::ST_OUT_OF_RANGE;
                                state_next      = bpfa_pkg::S_RESP;
                            end else begin
                                dvd_next   = PGB'(s_tdata[31:bpfa_pkg::PAGE_SHIFT]);
                                state_next = bpfa_pkg::S_DIV;
                            end
                        end
                        bpfa_pkg::REQ_INIT: begin
                            resv_next       = resv_eff;
                            sweep_init_next = 1'b1;
                            state_next      = bpfa_pkg::S_SWEEP;
                        end
                        default: begin
                            state_next = bpfa_pkg::S_RESP;
                        end
                    endcase
                end
            end

            bpfa_pkg::S_SCAN_RD: begin
                if (idx_reg == (WIW+1)'(WORD_COUNT) || base_reg >= XW'(eff_total)) begin
                    res_status_next = bpfa_pkg::ST_NO_MEMORY;
                    state_next      = bpfa_pkg::S_RESP;
                end else begin
                    state_next = bpfa_pkg::S_SCAN_CHK;
                end
            end

            bpfa_pkg::S_SCAN_CHK: begin
                if (rd_data_reg == FULL) begin
                    base_next  = alu_sum;
                    idx_next   = idx_reg + 1'b1;
                    state_next = bpfa_pkg::S_SCAN_RD;
                end else begin
                    alu_b      = XW'(first_zero);
                    state_next = bpfa_pkg::S_RESP;
                    if (alu_sum >= XW'(eff_total)) begin
                        res_status_next = bpfa_pkg::ST_NO_MEMORY;
                    end else begin
                        mem_we        = 1'b1;
                        mem_wdata     = rd_data_reg | (WORD_BITS'(1) << first_zero);
                        cnt_next      = cnt_reg + 1'b1;
                        res_addr_next = bpfa_pkg::ADDR_W'({alu_sum,
                                                           {bpfa_pkg::PAGE_SHIFT{1'b0}}});
                    end
                end
            end

            bpfa_pkg::S_DIV: begin
                q_next     = div_prod[DK +: WIW];
                state_next = bpfa_pkg::S_FREE_RD;
            end

            // bit index = page - word index * word size
            bpfa_pkg::S_FREE_RD: begin
                mem_raddr  = q_reg;
                alu_a      = XW'(dvd_reg);
                alu_b      = ~(XW'(q_reg) * XW'(WORD_BITS));
                alu_cin    = 1'b1;
                rem_next   = alu_sum[BIW-1:0];
                state_next = bpfa_pkg::S_FREE_CHK;
            end

            bpfa_pkg::S_FREE_CHK: begin
                mem_waddr  = q_reg;
                state_next = bpfa_pkg::S_RESP;
                if (!rd_data_reg[rem_reg]) begin
                    res_status_next = bpfa_pkg::ST_NOT_ALLOCATED;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg & ~(WORD_BITS'(1) << rem_reg);
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end

            bpfa_pkg::S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_count_next  = cnt_reg;
                    sweep_init_next = 1'b0;
                    state_next      = bpfa_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = bpfa_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{bpfa_pkg::M_PAD_W{1'b0}}, out_count_reg, out_addr_reg};

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(MAX_PAGES))
        else $error("used count above page capacity");

    a_alloc_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpfa_pkg::S_SCAN_CHK && mem_we) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("alloc did not bump used count");

    a_free_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpfa_pkg::S_FREE_CHK && mem_we) |=> cnt_reg <= $past(cnt_reg))
        else $error("free raised used count");

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> 32'(mem_waddr) < 32'(WORD_COUNT))
        else $error("bitmap write past last word");

    a_err_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg != bpfa_pkg::ST_OK) |-> out_addr_reg == '0)
        else $error("failed request carries an address");
`endif

endmodule
